@@ rtl/lbs_pkg.sv @@
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, field layout and saturation helpers for the skinning unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int JOINT_COUNT_DEF = 64;
    localparam int ROW_WORDS       = 16;   // words per joint matrix
    localparam int ADDR_FULL_W     = 12;   // address width at the largest joint count
    localparam int JOINT_CMP_W     = 9;    // holds the largest joint count

    localparam int WORD_W  = 32;
    localparam int WGT_W   = 16;
    localparam int ACC_W   = 48;
    localparam int TERM_W  = 50;           // three products plus offset word
    localparam int ADD_W   = 51;           // accumulator plus weighted term
    localparam int PROD_W  = 64;
    localparam int HALF_W  = 24;           // split of the clamped term for the weight pass
    localparam int WPART_W = 41;           // 24-bit part times 17-bit weight

    // input beat layout
    localparam int IN_DATA_W = 160;
    localparam int OUT_DATA_W = 96;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SKIN = 1'b1;

    localparam logic signed [ADD_W-1:0] ACC_MAX = 51'sd140737488355327;
    localparam logic signed [ADD_W-1:0] ACC_MIN = -ACC_MAX - 51'sd1;
    localparam logic signed [ACC_W-1:0] OUT_MAX = 48'sd2147483647;
    localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - 48'sd1;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_RD0   = 12'b0000_0000_0010,
        S_MX    = 12'b0000_0000_0100,
        S_MY    = 12'b0000_0000_1000,
        S_MZ    = 12'b0000_0001_0000,
        S_M3    = 12'b0000_0010_0000,
        S_CLAMP = 12'b0000_0100_0000,
        S_WLO   = 12'b0000_1000_0000,
        S_WHI   = 12'b0001_0000_0000,
        S_ADD   = 12'b0010_0000_0000,
        S_ACC   = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } t_state;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ADD_W-1:0] v);
        logic signed [ADD_W-1:0] r;
        if (v > ACC_MAX) begin
            r = ACC_MAX;
        end else if (v < ACC_MIN) begin
            r = ACC_MIN;
        end else begin
            r = v;
        end
        return r[ACC_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX;
        end else if (v < OUT_MIN) begin
            r = OUT_MIN;
        end else begin
            r = v;
        end
        return r[WORD_W-1:0];
    endfunction

endpackage

@@ rtl/linear_blend_skinning.sv @@
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Skins a vertex as the weighted sum of its joint-transformed rest position,
// using one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat                                  Accepted when
// s_axis   in   load word or influence (tuser = op)   tvalid & tready
// m_axis   out  skinned x, y, z                       tvalid & tready
//
// A load beat writes the matrix table in its accept cycle; the block stays
// ready. An influence on a valid joint holds input ready low while it runs
// through each output column in turn (four matrix reads feeding three
// multiplies, a clamp, two multiplies for the weight, a combine and an
// accumulate), all through the one multiplier. A last influence then loads
// the output register, waiting while a previous result is still held by the
// sink. An influence on a joint past the table adds nothing; it returns to
// idle at once, or with last set goes straight to the output load.
// Reset clears the sums, sequencer and output valid; the table is not cleared.
// ----------------------------------------------------------------------------
module linear_blend_skinning #(
    parameter int JOINT_COUNT = lbs_pkg::JOINT_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // joint[5:0], element[9:6], matrix_word[41:10], pos_x[73:42],
    // pos_y[105:74], pos_z[137:106], weight[153:138], zero fill[159:154]
    input  logic [lbs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tlast,   // last_influence
    input  logic                               s_axis_tuser,   // operation
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [lbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int DEPTH = JOINT_COUNT * lbs_pkg::ROW_WORDS;
    localparam int AW    = $clog2(DEPTH);

    lbs_pkg::t_state r_state, n_state;

    logic [5:0]                              in_joint;
    logic [3:0]                              in_element;
    logic [lbs_pkg::WORD_W-1:0]              in_word;
    logic signed [lbs_pkg::WORD_W-1:0]       r_px, r_py, r_pz;
    logic [lbs_pkg::WGT_W-1:0]               r_w;
    logic [5:0]                              r_joint;
    logic                                    r_last;
    logic [1:0]                              r_col;
    logic                                    in_range;
    logic                                    accept;

    logic [lbs_pkg::ADDR_FULL_W-1:0]         waddr_full, raddr_full;
    logic [1:0]                              rd_row;
    logic [lbs_pkg::WORD_W-1:0]              rdata;

    logic signed [lbs_pkg::WORD_W-1:0]       mul_a, mul_b;
    logic signed [lbs_pkg::PROD_W-1:0]       prod;

    logic signed [lbs_pkg::TERM_W-1:0]       r_t;
    logic signed [lbs_pkg::TERM_W-1:0]       term;
    logic signed [lbs_pkg::ACC_W-1:0]        r_tc;
    logic [lbs_pkg::WPART_W-1:0]             r_plo;
    logic signed [lbs_pkg::TERM_W-1:0]       r_add;
    logic signed [lbs_pkg::ACC_W+17:0]       wsum;
    logic signed [lbs_pkg::ADD_W-1:0]        acc_sum;
    logic signed [lbs_pkg::ACC_W-1:0]        r_sum [3];

    logic                                    r_out_valid;
    logic [lbs_pkg::OUT_DATA_W-1:0]          r_out_data;

    assign in_joint   = s_axis_tdata[5:0];
    assign in_element = s_axis_tdata[9:6];
    assign in_word    = s_axis_tdata[41:10];
    assign in_range   = {3'b000, in_joint} < lbs_pkg::JOINT_CMP_W'(JOINT_COUNT);

    assign s_axis_tready = i_rst_n && (r_state == lbs_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------- table ----------------
    assign waddr_full = {2'b00, in_joint, in_element};
    assign raddr_full = {2'b00, r_joint, rd_row, r_col};

    always_comb begin
        unique case (r_state)
            lbs_pkg::S_MX: rd_row = 2'd1;
            lbs_pkg::S_MY: rd_row = 2'd2;
            lbs_pkg::S_MZ: rd_row = 2'd3;
            default:       rd_row = 2'd0;
        endcase
    end

    lbs_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (accept && (s_axis_tuser == lbs_pkg::OP_LOAD) && in_range),
        .i_waddr (waddr_full[AW-1:0]),
        .i_wdata (in_word),
        .i_raddr (raddr_full[AW-1:0]),
        .o_rdata (rdata)
    );

    // ---------------- shared multiplier ----------------
    always_comb begin
        unique case (r_state)
            lbs_pkg::S_MX: begin
                mul_a = r_px;
                mul_b = signed'(rdata);
            end
            lbs_pkg::S_MY: begin
                mul_a = r_py;
                mul_b = signed'(rdata);
            end
            lbs_pkg::S_MZ: begin
                mul_a = r_pz;
                mul_b = signed'(rdata);
            end
            lbs_pkg::S_WLO: begin
                mul_a = signed'({8'd0, r_tc[lbs_pkg::HALF_W-1:0]});
                mul_b = signed'({16'd0, r_w});
            end
            lbs_pkg::S_WHI: begin
                mul_a = lbs_pkg::WORD_W'(signed'(r_tc[lbs_pkg::ACC_W-1:lbs_pkg::HALF_W]));
                mul_b = signed'({16'd0, r_w});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lbs_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // product in Q32.32, floor to Q32.16
    assign term = lbs_pkg::TERM_W'(signed'(prod[lbs_pkg::PROD_W-1:16]));

    // high part of the weighted term sits 24 bits up; floor by 15 afterwards
    assign wsum = ((lbs_pkg::ACC_W+18)'(signed'(prod[lbs_pkg::WPART_W-1:0]))
                   <<< lbs_pkg::HALF_W)
                + signed'({25'd0, r_plo});

    assign acc_sum = lbs_pkg::ADD_W'(r_sum[r_col]) + lbs_pkg::ADD_W'(r_add);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbs_pkg::S_IDLE: begin
                if (accept && (s_axis_tuser == lbs_pkg::OP_SKIN)) begin
                    if (in_range) begin
                        n_state = lbs_pkg::S_RD0;
                    end else if (s_axis_tlast) begin
                        n_state = lbs_pkg::S_OUT;
                    end
                end
            end
            lbs_pkg::S_RD0:   n_state = lbs_pkg::S_MX;
            lbs_pkg::S_MX:    n_state = lbs_pkg::S_MY;
            lbs_pkg::S_MY:    n_state = lbs_pkg::S_MZ;
            lbs_pkg::S_MZ:    n_state = lbs_pkg::S_M3;
            lbs_pkg::S_M3:    n_state = lbs_pkg::S_CLAMP;
            lbs_pkg::S_CLAMP: n_state = lbs_pkg::S_WLO;
            lbs_pkg::S_WLO:   n_state = lbs_pkg::S_WHI;
            lbs_pkg::S_WHI:   n_state = lbs_pkg::S_ADD;
            lbs_pkg::S_ADD:   n_state = lbs_pkg::S_ACC;
            lbs_pkg::S_ACC: begin
                if (r_col != 2'd2) begin
                    n_state = lbs_pkg::S_RD0;
                end else if (r_last) begin
                    n_state = lbs_pkg::S_OUT;
                end else begin
                    n_state = lbs_pkg::S_IDLE;
                end
            end
            lbs_pkg::S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = lbs_pkg::S_IDLE;
                end
            end
            default: n_state = lbs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbs_pkg::S_IDLE;
            r_col       <= 2'd0;
            r_out_valid <= 1'b0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lbs_pkg::S_IDLE) begin
                r_col <= 2'd0;
            end
            if (r_state == lbs_pkg::S_ACC) begin
                r_sum[r_col] <= lbs_pkg::sat_acc(acc_sum);
                r_col        <= r_col + 2'd1;
            end
            // drain the sums into the output beat once the register is free
            if ((r_state == lbs_pkg::S_OUT) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
                r_sum[0]    <= '0;
                r_sum[1]    <= '0;
                r_sum[2]    <= '0;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept && (s_axis_tuser == lbs_pkg::OP_SKIN)) begin
            r_joint <= in_joint;
            r_px    <= signed'(s_axis_tdata[73:42]);
            r_py    <= signed'(s_axis_tdata[105:74]);
            r_pz    <= signed'(s_axis_tdata[137:106]);
            r_w     <= s_axis_tdata[153:138];
            r_last  <= s_axis_tlast;
        end
        unique case (r_state)
            lbs_pkg::S_MY:    r_t   <= term;
            lbs_pkg::S_MZ:    r_t   <= r_t + term;
            lbs_pkg::S_M3:    r_t   <= r_t + term
                                     + lbs_pkg::TERM_W'(signed'(rdata));
            lbs_pkg::S_CLAMP: r_tc  <= lbs_pkg::sat_acc(lbs_pkg::ADD_W'(r_t));
            lbs_pkg::S_WHI:   r_plo <= prod[lbs_pkg::WPART_W-1:0];
            lbs_pkg::S_ADD:   r_add <= wsum[lbs_pkg::ACC_W+16:15];
            lbs_pkg::S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    r_out_data <= {lbs_pkg::sat_out(r_sum[2]),
                                   lbs_pkg::sat_out(r_sum[1]),
                                   lbs_pkg::sat_out(r_sum[0])};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ rtl/lbs_table.sv @@
// ----------------------------------------------------------------------------
// lbs_table
// Joint matrix store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbs_table #(
    parameter int DEPTH = lbs_pkg::JOINT_COUNT_DEF * lbs_pkg::ROW_WORDS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [lbs_pkg::WORD_W-1:0]  i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [lbs_pkg::WORD_W-1:0]  o_rdata
);

    logic [lbs_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [lbs_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lbs_mul.sv @@
// ----------------------------------------------------------------------------
// lbs_mul
// Shared signed 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module lbs_mul (
    input  logic                               i_clk,
    input  logic signed [lbs_pkg::WORD_W-1:0]  i_a,
    input  logic signed [lbs_pkg::WORD_W-1:0]  i_b,
    output logic signed [lbs_pkg::PROD_W-1:0]  o_prod
);

    logic signed [lbs_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ tb/linear_blend_skinning_test.sv @@
// ----------------------------------------------------------------------------
// linear_blend_skinning_test
// Self-checking bench for the skinning unit: matrix words and vertex
// influences go in on the input stream, and a bit-exact skinning predictor
// tracks the joint table and the running sums. Each skinned vertex that comes
// out is compared field by field against the oldest predicted vertex. Random
// gaps and stalls, a long sink hold-off and drain pauses cover flow control.
// ----------------------------------------------------------------------------
module linear_blend_skinning_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int JOINT_COUNT   = lbs_pkg::JOINT_COUNT_DEF;
    localparam int TABLE_WORDS   = JOINT_COUNT * lbs_pkg::ROW_WORDS;
    localparam int ITEM_TARGET   = 950;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -ACC_HI - 64'sd1;
    localparam longint OUT_HI = 64'sd2147483647;
    localparam longint OUT_LO = -OUT_HI - 64'sd1;

    localparam logic signed [31:0] WORD_HI = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_LO = 32'sh8000_0000;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic [15:0]        WGT_ONE = 16'd32768;
    localparam logic [15:0]        WGT_TOP = 16'd65535;

    typedef struct {
        logic              op;
        logic [5:0]        joint;
        logic [3:0]        element;
        logic signed [31:0] word;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [15:0]       weight;
        logic              last;
    } skin_beat_t;

    typedef logic [lbs_pkg::OUT_DATA_W-1:0] skinned_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lbs_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

    // predictor state
    logic signed [31:0] matrix_words [TABLE_WORDS];
    bit                 word_loaded [TABLE_WORDS];
    longint             sum_x = 0;
    longint             sum_y = 0;
    longint             sum_z = 0;
    skinned_t           pending_vertices [$];

    int          error_count   = 0;
    int unsigned beats_sent    = 0;
    int unsigned cycle_count   = 0;
    bit          idle_on       = 1'b0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          sink_wait     = 0;
    string       coord_name [3] = '{"out_x", "out_y", "out_z"};

    linear_blend_skinning #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // skinning predictor
    // ------------------------------------------------------------------
    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // one column of (x,y,z,1) * M, clamped to the accumulator range, then weighted
    function automatic longint weighted_column(int unsigned base, int unsigned col,
                                               longint px, longint py, longint pz,
                                               longint w);
        longint m0;
        longint m1;
        longint m2;
        longint m3;
        longint t;
        m0 = longint'(matrix_words[base + col]);
        m1 = longint'(matrix_words[base + 4 + col]);
        m2 = longint'(matrix_words[base + 8 + col]);
        m3 = longint'(matrix_words[base + 12 + col]);
        t = ((px * m0) >>> 16) + ((py * m1) >>> 16) + ((pz * m2) >>> 16) + m3;
        t = clamp(t, ACC_LO, ACC_HI);
        return (t * w) >>> 15;
    endfunction

    function automatic void skin_predict(skin_beat_t b);
        int unsigned base;
        longint      w;
        longint      px;
        longint      py;
        longint      pz;
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] oz;
        base = int'(b.joint) * lbs_pkg::ROW_WORDS;
        if (b.op == lbs_pkg::OP_LOAD) begin
            if (b.joint < JOINT_COUNT) begin
                matrix_words[base + b.element] = b.word;
                word_loaded[base + b.element]  = 1'b1;
            end
            return;
        end
        if (b.joint < JOINT_COUNT) begin
            w  = longint'(b.weight);
            px = longint'(b.px);
            py = longint'(b.py);
            pz = longint'(b.pz);
            sum_x = clamp(sum_x + weighted_column(base, 0, px, py, pz, w),
                          ACC_LO, ACC_HI);
            sum_y = clamp(sum_y + weighted_column(base, 1, px, py, pz, w),
                          ACC_LO, ACC_HI);
            sum_z = clamp(sum_z + weighted_column(base, 2, px, py, pz, w),
                          ACC_LO, ACC_HI);
        end
        if (b.last) begin
            ox = 32'(clamp(sum_x, OUT_LO, OUT_HI));
            oy = 32'(clamp(sum_y, OUT_LO, OUT_HI));
            oz = 32'(clamp(sum_z, OUT_LO, OUT_HI));
            pending_vertices.insert(pending_vertices.size(), {oz, oy, ox});
            sum_x = 0;
            sum_y = 0;
            sum_z = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // random value pickers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return WORD_HI;
            1: return WORD_LO;
            2: return ONE_Q16;
            3: return -ONE_Q16;
            default: return '0;
        endcase
    endfunction

    // mostly within +-2.0 so results stay in range, with corners mixed in
    function automatic logic signed [31:0] pick_matrix_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return pick_extreme();
        end
        if (r < 20) begin
            return $urandom;
        end
        return int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    // mostly within +-256.0
    function automatic logic signed [31:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return pick_extreme();
        end
        if (r < 25) begin
            return $urandom;
        end
        return int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endfunction

    function automatic logic [15:0] pick_weight();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return WGT_ONE;
        end
        if (r < 8) begin
            return '0;
        end
        if (r < 10) begin
            return WGT_TOP;
        end
        if (r < 20) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'($urandom_range(0, 32768));
    endfunction

    // every field random, so unused fields toggle too
    function automatic skin_beat_t random_beat();
        skin_beat_t b;
        b.op      = 1'($urandom_range(0, 1));
        b.joint   = 6'($urandom_range(0, 63));
        b.element = 4'($urandom_range(0, 15));
        b.word    = $urandom;
        b.px      = $urandom;
        b.py      = $urandom;
        b.pz      = $urandom;
        b.weight  = 16'($urandom_range(0, 65535));
        b.last    = 1'($urandom_range(0, 1));
        return b;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_beat(skin_beat_t b);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, b.weight, b.pz, b.py, b.px, b.word, b.element, b.joint};
        s_axis_tlast  <= b.last;
        s_axis_tuser  <= b.op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        skin_predict(b);
        beats_sent++;
    endtask

    task automatic send_load(logic [5:0] joint, logic [3:0] element,
                             logic signed [31:0] word, logic last);
        skin_beat_t b;
        b = random_beat();
        b.op      = lbs_pkg::OP_LOAD;
        b.joint   = joint;
        b.element = element;
        b.word    = word;
        b.last    = last;
        send_beat(b);
    endtask

    task automatic send_skin(logic [5:0] joint, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] pz,
                             logic [15:0] weight, logic last);
        skin_beat_t b;
        b = random_beat();
        b.op     = lbs_pkg::OP_SKIN;
        b.joint  = joint;
        b.px     = px;
        b.py     = py;
        b.pz     = pz;
        b.weight = weight;
        b.last   = last;
        send_beat(b);
    endtask

    // fill whatever words of the joint an influence reads and are still unset;
    // now and then reload all of them with fresh values
    task automatic load_joint(logic [5:0] joint);
        bit          refresh;
        int unsigned base;
        refresh = ($urandom_range(0, 19) == 0);
        base = int'(joint) * lbs_pkg::ROW_WORDS;
        for (int e = 0; e < lbs_pkg::ROW_WORDS; e++) begin
            if (e % 4 != 3 && (refresh || !word_loaded[base + e])) begin
                send_load(joint, e[3:0], pick_matrix_word(), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_vertices.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // output side: ready with random stalls, plus a requested long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            sink_wait     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait     <= sink_wait - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            sink_wait     <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_vertex
        skinned_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_vertices.size() == 0) begin
                $display("%0t: vertex out with none expected, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_vertices.pop_front();
                for (int f = 0; f < 3; f++) begin
                    if (want[f*32 +: 32] !== m_axis_tdata[f*32 +: 32]) begin
                        $display("%0t: %s mismatch, expected %h, actual %h", $time,
                                 coord_name[f], want[f*32 +: 32], m_axis_tdata[f*32 +: 32]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // joint 63: column x all max, column y all min, column z picks z;
    // drives accumulator and output saturation both ways, zero and top weights
    task automatic test_directed_corners();
        logic signed [31:0] word;
        for (int e = 0; e < lbs_pkg::ROW_WORDS; e++) begin
            if (e % 4 != 3 || e == 15) begin
                case (e % 4)
                    0: word = WORD_HI;
                    1: word = WORD_LO;
                    2: word = (e == 10) ? ONE_Q16 : '0;
                    default: word = $urandom;
                endcase
                // the unused last word goes with last set: a load never emits
                send_load(6'd63, e[3:0], word, e == 15);
            end
        end
        send_skin(6'd63, WORD_HI, WORD_HI, WORD_HI, WGT_TOP, 1'b0);
        send_skin(6'd63, WORD_HI, WORD_HI, WORD_HI, WGT_TOP, 1'b1);
        send_skin(6'd63, WORD_LO, WORD_LO, WORD_LO, WGT_ONE, 1'b1);
        send_skin(6'd63, '0, '0, '0, '0, 1'b1);
        send_skin(6'd63, ONE_Q16, -ONE_Q16, WORD_HI, 16'd1, 1'b1);
        send_skin(6'd63, WORD_LO, WORD_HI, ONE_Q16, WGT_ONE, 1'b0);
        send_skin(6'd63, WORD_HI, WORD_LO, -ONE_Q16, WGT_TOP, 1'b1);
    endtask

    // vertices of one to four influences on random joints, with stray loads
    task automatic test_random_vertices(int unsigned beat_target, bit with_pauses);
        int n;
        logic [5:0] joint;
        while (beats_sent < beat_target) begin
            if ($urandom_range(0, 99) < 12) begin
                send_load(6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                          pick_matrix_word(), 1'($urandom_range(0, 1)));
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 1; i <= n; i++) begin
                    joint = 6'($urandom_range(0, 63));
                    if ($urandom_range(0, 9) == 0) begin
                        send_load(6'($urandom_range(0, 63)), 4'($urandom_range(0, 15)),
                                  pick_matrix_word(), 1'($urandom_range(0, 1)));
                    end
                    load_joint(joint);
                    send_skin(joint, pick_coord(), pick_coord(), pick_coord(), pick_weight(),
                              i == n);
                end
                if (with_pauses && $urandom_range(0, 29) == 0) begin
                    wait_for_results();
                end
            end
        end
    endtask

    // sink holds off while single-influence vertices keep coming, so the
    // block backs up and drops its input ready; then drain completely
    task automatic test_sink_backpressure();
        idle_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 12; i++) begin
            send_skin(6'd63, pick_coord(), pick_coord(), pick_coord(), pick_weight(), 1'b1);
        end
        wait_for_results();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_corners();
        test_random_vertices(beats_sent + 150, 1'b0);
        test_sink_backpressure();
        idle_on = 1'b1;
        test_random_vertices(ITEM_TARGET, 1'b1);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_vertices.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lbs_pkg.sv
rtl/lbs_table.sv
rtl/lbs_mul.sv
rtl/linear_blend_skinning.sv
tb/linear_blend_skinning_test.sv
